// ===== src/hsc_pkg.sv =====
// Shared types and constants for the host name syntax checker.
`timescale 1ns / 1ps
`default_nettype none
package hsc_pkg;

    // Greatest name length limit ever applied, whatever the register holds.
    localparam logic [9:0] LENGTH_BOUND = 10'd255;
    localparam logic [6:0] LABEL_MAX    = 7'd63;
    localparam logic [8:0] NAME_SAT     = 9'd256;
    localparam int         FIFO_DEPTH   = 4;

    localparam logic [7:0] CHAR_DOT    = 8'h2e;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

    typedef enum logic [2:0] {
        REASON_OK           = 3'd0,
        REASON_EMPTY        = 3'd1,
        REASON_TOO_LONG     = 3'd2,
        REASON_BAD_CHAR     = 3'd3,
        REASON_EMPTY_LABEL  = 3'd4,
        REASON_EDGE_HYPHEN  = 3'd5,
        REASON_LONG_LABEL   = 3'd6,
        REASON_TRAILING_DOT = 3'd7
    } reason_t;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_DOT    = 3'd1,
        CLS_HYPHEN = 3'd2,
        CLS_LABEL  = 3'd3,
        CLS_BAD    = 3'd4
    } char_class_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic       name_ok;
        logic [2:0] fail_reason;
        logic [8:0] name_length;
    } result_t;

    // Classified item passed from front to back through the queue.
    typedef struct packed {
        char_class_t cls;
        logic        is_last;
    } entry_t;

endpackage
`default_nettype wire

// ===== src/hsc_front.sv =====
// Front end: accepts character items and classifies each character.
`timescale 1ns / 1ps
`default_nettype none
module hsc_front (
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire hsc_pkg::item_t item,
    input  wire logic           q_full,
    output logic                q_push,
    output hsc_pkg::entry_t     q_entry
);
    import hsc_pkg::*;

    logic is_alpha;
    logic is_digit;

    assign is_alpha = ((item.char_code >= 8'h61) && (item.char_code <= 8'h7a))
                   || ((item.char_code >= 8'h41) && (item.char_code <= 8'h5a));
    assign is_digit = (item.char_code >= 8'h30) && (item.char_code <= 8'h39);

    assign item_ready = !q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        q_entry.is_last = item.is_last;
        if (!item.has_char)
            q_entry.cls = CLS_NONE;
        else if (item.char_code == CHAR_DOT)
            q_entry.cls = CLS_DOT;
        else if (item.char_code == CHAR_HYPHEN)
            q_entry.cls = CLS_HYPHEN;
        else if (is_alpha || is_digit)
            q_entry.cls = CLS_LABEL;
        else
            q_entry.cls = CLS_BAD;
    end

endmodule
`default_nettype wire

// ===== src/hsc_fifo.sv =====
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module hsc_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hsc_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output hsc_pkg::entry_t      head
);
    import hsc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

    entry_t           slots_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count above depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== src/hsc_back.sv =====
// Back end: label and length rules, verdict and result register.
`timescale 1ns / 1ps
`default_nettype none
module hsc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      max_length,
    input  wire logic            q_not_empty,
    input  wire hsc_pkg::entry_t q_head,
    output logic                 q_pop,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output hsc_pkg::result_t     result
);
    import hsc_pkg::*;

    logic [8:0] chars_seen_reg, chars_seen_next;
    logic [6:0] label_chars_reg, label_chars_next;
    logic       prev_hyphen_reg, prev_hyphen_next;
    reason_t    first_fault_reg, first_fault_next;
    logic       result_valid_reg, result_valid_next;
    result_t    result_reg, result_next;

    // Updated name state after the head item's character.
    logic [8:0] seen_upd;
    logic [6:0] label_upd;
    logic       hyph_upd;
    reason_t    fault_upd;
    reason_t    verdict;
    logic [9:0] limit;
    logic [6:0] label_inc;
    logic       out_free;

    assign out_free = !result_valid_reg || result_ready;
    assign q_pop    = q_not_empty && (!q_head.is_last || out_free);
    assign limit    = ({2'b00, max_length} > LENGTH_BOUND) ? LENGTH_BOUND
                                                           : {2'b00, max_length};
    assign label_inc = label_chars_reg + 1'b1;

    always_comb
    begin
        seen_upd  = chars_seen_reg;
        label_upd = label_chars_reg;
        hyph_upd  = prev_hyphen_reg;
        fault_upd = first_fault_reg;
        if (q_head.cls != CLS_NONE)
        begin
            if (chars_seen_reg != NAME_SAT)
                seen_upd = chars_seen_reg + 1'b1;
            if (first_fault_reg == REASON_OK)
            begin
                hyph_upd = (q_head.cls == CLS_HYPHEN);
                case (q_head.cls)
                    CLS_DOT:
                    begin
                        if (label_chars_reg == '0)
                            fault_upd = REASON_EMPTY_LABEL;
                        else if (prev_hyphen_reg)
                            fault_upd = REASON_EDGE_HYPHEN;
                        else
                            label_upd = '0;
                    end
                    CLS_BAD:
                        fault_upd = REASON_BAD_CHAR;
                    CLS_HYPHEN, CLS_LABEL:
                    begin
                        if (label_chars_reg == '0 && q_head.cls == CLS_HYPHEN)
                            fault_upd = REASON_EDGE_HYPHEN;
                        else
                        begin
                            label_upd = label_inc;
                            if (label_inc > LABEL_MAX)
                                fault_upd = REASON_LONG_LABEL;
                        end
                    end
                    default:
                        fault_upd = first_fault_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        if (seen_upd == '0)
            verdict = REASON_EMPTY;
        else if ({1'b0, seen_upd} > limit)
            verdict = REASON_TOO_LONG;
        else if (fault_upd != REASON_OK)
            verdict = fault_upd;
        else if (label_upd == '0)
            verdict = REASON_TRAILING_DOT;
        else if (hyph_upd)
            verdict = REASON_EDGE_HYPHEN;
        else
            verdict = REASON_OK;
    end

    always_comb
    begin
        chars_seen_next   = chars_seen_reg;
        label_chars_next  = label_chars_reg;
        prev_hyphen_next  = prev_hyphen_reg;
        first_fault_next  = first_fault_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (q_pop)
        begin
            if (q_head.is_last)
            begin
                chars_seen_next         = '0;
                label_chars_next        = '0;
                prev_hyphen_next        = 1'b0;
                first_fault_next        = REASON_OK;
                result_valid_next       = 1'b1;
                result_next.name_ok     = (verdict == REASON_OK);
                result_next.fail_reason = verdict;
                result_next.name_length = seen_upd;
            end
            else
            begin
                chars_seen_next  = seen_upd;
                label_chars_next = label_upd;
                prev_hyphen_next = hyph_upd;
                first_fault_next = fault_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg   <= '0;
            label_chars_reg  <= '0;
            prev_hyphen_reg  <= 1'b0;
            first_fault_reg  <= REASON_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            chars_seen_reg   <= chars_seen_next;
            label_chars_reg  <= label_chars_next;
            prev_hyphen_reg  <= prev_hyphen_next;
            first_fault_reg  <= first_fault_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
        label_chars_reg <= (LABEL_MAX + 7'd1))
        else $error("label count past saturation point");
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chars_seen_reg <= NAME_SAT)
        else $error("name count past saturation");
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.is_last) |=> (chars_seen_reg == '0 && result_valid_reg))
        else $error("name state not cleared after end item");

endmodule
`default_nettype wire

// ===== src/hostname_syntax_checker.sv =====
// Top level: host name checker with config register, front, queue and back.
// An end item goes through a queue slot and then the result register.
// Throughput: one item per cycle at the back's pop; a held result stalls end items.
// A four-entry queue lets the front keep accepting while a result waits.
// Reset clears all name state, the queue and the result valid; max_length resets to 253.
`timescale 1ns / 1ps
`default_nettype none
module hostname_syntax_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire hsc_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output hsc_pkg::result_t      result
);
    import hsc_pkg::*;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd253;

    logic [7:0] max_length_reg, max_length_next;
    logic       wr_en;
    logic       q_push, q_pop, q_full, q_not_empty;
    entry_t     q_in, q_head;

    // Register 0 sits at byte address 0; paddr[2] set is outside the map.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {24'd0, max_length_reg};

    always_comb
    begin
        max_length_next = wr_en ? pwdata[7:0] : max_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else
            max_length_reg <= max_length_next;
    end

    hsc_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    hsc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    hsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_length   (max_length_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the host name syntax checker.
`timescale 1ns / 1ps
module testbench;
    import hsc_pkg::*;

    localparam logic [2:0] REG_MAX_LENGTH = 3'd0;
    localparam int LONG_HOLD       = 200;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 4;

    typedef enum int {
        DAMAGE_BYTE,
        DAMAGE_DOUBLE_DOT,
        DAMAGE_LEAD_HYPHEN,
        DAMAGE_TAIL_DOT,
        DAMAGE_TAIL_HYPHEN,
        DAMAGE_LEAD_DOT
    } damage_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    hostname_syntax_checker dut (.*);

    // predictor state for the name in progress
    logic [7:0] length_limit = 8'd253;
    logic [8:0] cur_length   = '0;
    logic [6:0] cur_label    = '0;
    logic       cur_hyphen   = 1'b0;
    reason_t    cur_fault    = REASON_OK;

    item_t      item_stream[$];
    result_t    expected_verdicts[$];
    logic [7:0] name_buf[$];

    int items_pushed      = 0;
    int items_accepted    = 0;
    int items_counted     = 0;
    int fail_count        = 0;
    int quiet_cycles      = 0;
    int send_gap          = 0;
    int send_calm         = 0;
    int recv_calm         = 0;
    int hold_left         = 0;
    int recv_gap          = 0;
    int long_holds_wanted = 0;
    int long_holds_done   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10)
            return 8'(k + 'h30);
        else if (k < 36)
            return 8'(k - 10 + 'h41);
        return 8'(k - 36 + 'h61);
    endfunction

    task automatic predict_verdict(input item_t it);
        reason_t    why;
        result_t    verdict;
        logic [9:0] eff_limit;
        logic [7:0] c;
        c = it.char_code;
        if (it.has_char)
        begin
            if (cur_length < NAME_SAT)
                cur_length = cur_length + 1'b1;
            // once a fault is latched only the length keeps moving
            if (cur_fault == REASON_OK)
            begin
                if (c == CHAR_DOT)
                begin
                    if (cur_label == 0)
                        cur_fault = REASON_EMPTY_LABEL;
                    else if (cur_hyphen)
                        cur_fault = REASON_EDGE_HYPHEN;
                    else
                        cur_label = '0;
                end
                else if (!((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                           (c >= 8'h30 && c <= 8'h39) || c == CHAR_HYPHEN))
                    cur_fault = REASON_BAD_CHAR;
                else if (cur_label == 0 && c == CHAR_HYPHEN)
                    cur_fault = REASON_EDGE_HYPHEN;
                else
                begin
                    cur_label = cur_label + 1'b1;
                    if (cur_label > LABEL_MAX)
                        cur_fault = REASON_LONG_LABEL;
                end
                cur_hyphen = (c == CHAR_HYPHEN);
            end
        end
        if (it.is_last)
        begin
            eff_limit = ({2'b00, length_limit} > LENGTH_BOUND) ? LENGTH_BOUND
                                                                : {2'b00, length_limit};
            if (cur_length == 0)
                why = REASON_EMPTY;
            else if ({1'b0, cur_length} > eff_limit)
                why = REASON_TOO_LONG;
            else if (cur_fault != REASON_OK)
                why = cur_fault;
            else if (cur_label == 0)
                why = REASON_TRAILING_DOT;
            else if (cur_hyphen)
                why = REASON_EDGE_HYPHEN;
            else
                why = REASON_OK;
            verdict.name_ok     = (why == REASON_OK);
            verdict.fail_reason = why;
            verdict.name_length = cur_length;
            expected_verdicts.push_back(verdict);
            cur_length = '0;
            cur_label  = '0;
            cur_hyphen = 1'b0;
            cur_fault  = REASON_OK;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [8:0] want,
                                 input logic [8:0] got);
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        fail_count++;
    endtask

    // Turns name_buf into items, with the odd bare no-op item mixed in.
    task automatic push_name(input bit bare_end);
        item_t it;
        for (int i = 0; i < name_buf.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                it.char_code = 8'($urandom_range(0, 255));
                it.has_char  = 1'b0;
                it.is_last   = 1'b0;
                item_stream.push_back(it);
                items_pushed++;
            end
            it.char_code = name_buf[i];
            it.has_char  = 1'b1;
            it.is_last   = !bare_end && (i == name_buf.size() - 1);
            item_stream.push_back(it);
            items_pushed++;
            items_counted++;
        end
        if (bare_end || name_buf.size() == 0)
        begin
            it.char_code = 8'($urandom_range(0, 255));
            it.has_char  = 1'b0;
            it.is_last   = 1'b1;
            item_stream.push_back(it);
            items_pushed++;
            items_counted++;
        end
    endtask

    task automatic push_text(input string s, input bit bare_end);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        push_name(bare_end);
    endtask

    // Alphanumeric labels of label_len characters joined by dots.
    task automatic make_long_name(input int total, input int label_len);
        name_buf.delete();
        for (int i = 0; i < total; i++)
            name_buf.push_back((i % (label_len + 1) == label_len) ? CHAR_DOT : rand_alnum());
        push_name(1'b0);
    endtask

    task automatic make_name();
        int      labels;
        int      len;
        damage_t damage;
        name_buf.delete();
        if ($urandom_range(0, 99) >= 4)
        begin
            labels = $urandom_range(1, 4);
            for (int l = 0; l < labels; l++)
            begin
                if (l != 0)
                    name_buf.push_back(CHAR_DOT);
                len = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 66) : $urandom_range(1, 10);
                for (int j = 0; j < len; j++)
                begin
                    if (j > 0 && j < len - 1 && $urandom_range(0, 5) == 0)
                        name_buf.push_back(CHAR_HYPHEN);
                    else
                        name_buf.push_back(rand_alnum());
                end
            end
            if ($urandom_range(0, 99) < 35)
            begin
                damage = damage_t'($urandom_range(0, 5));
                case (damage)
                    DAMAGE_BYTE:
                        name_buf[$urandom_range(0, name_buf.size() - 1)] =
                            8'($urandom_range(0, 255));
                    DAMAGE_DOUBLE_DOT:
                        name_buf.insert($urandom_range(0, name_buf.size()), CHAR_DOT);
                    DAMAGE_LEAD_HYPHEN:
                        name_buf[0] = CHAR_HYPHEN;
                    DAMAGE_TAIL_DOT:
                        name_buf.push_back(CHAR_DOT);
                    DAMAGE_TAIL_HYPHEN:
                        name_buf.push_back(CHAR_HYPHEN);
                    default:
                        name_buf.push_front(CHAR_DOT);
                endcase
            end
        end
        push_name($urandom_range(0, 3) == 0);
    endtask

    task automatic fill_names(input int budget);
        int start;
        start = items_counted;
        while (items_counted - start < budget)
            make_name();
    endtask

    task automatic wait_idle();
        while (items_accepted != items_pushed || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_LENGTH;
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        length_limit = value;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_verdict(item);
                items_accepted++;
            end
            if (send_calm != 0)
                send_calm--;
            else if ($urandom_range(0, 39) == 0)
                send_calm = $urandom_range(15, 50);
            if (!item_valid || item_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (item_stream.size() != 0)
                begin
                    item       <= item_stream.pop_front();
                    item_valid <= 1'b1;
                    send_gap = (send_calm != 0) ? 0 : pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver ready pattern, including the forced long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (recv_calm != 0)
                recv_calm--;
            else if ($urandom_range(0, 39) == 0)
                recv_calm = $urandom_range(15, 50);
            if (long_holds_done != long_holds_wanted)
            begin
                long_holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                recv_gap = (recv_calm != 0) ? 0 : pick_gap();
                if (recv_gap == 0)
                    result_ready <= 1'b1;
                else
                begin
                    hold_left = recv_gap - 1;
                    result_ready <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_verdicts.size() == 0)
                flag_mismatch("result with none pending, name_length", '0, result.name_length);
            else
            begin
                if (result.name_ok !== expected_verdicts[0].name_ok)
                    flag_mismatch("name_ok", {8'd0, expected_verdicts[0].name_ok},
                                  {8'd0, result.name_ok});
                if (result.fail_reason !== expected_verdicts[0].fail_reason)
                    flag_mismatch("fail_reason", {6'd0, expected_verdicts[0].fail_reason},
                                  {6'd0, result.fail_reason});
                if (result.name_length !== expected_verdicts[0].name_length)
                    flag_mismatch("name_length", expected_verdicts[0].name_length,
                                  result.name_length);
                void'(expected_verdicts.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names at the reset limit of 253
        push_text("", 1'b1);
        push_text("a", 1'b0);
        push_text("A-z", 1'b0);
        push_text(".a", 1'b0);
        push_text("-a", 1'b0);
        push_text("a-", 1'b0);
        push_text("a.", 1'b0);
        push_text("a-.b", 1'b0);
        push_text(".-", 1'b0);
        push_text("z9", 1'b1);
        item_stream.push_back(item_t'{char_code: 8'hff, has_char: 1'b0, is_last: 1'b0});
        items_pushed++;
        name_buf = '{8'h00};
        push_name(1'b0);
        name_buf = '{8'hff, 8'h61};
        push_name(1'b1);
        wait_idle();

        // widest limit: exact fit, saturating length, over-long label
        write_max_length(8'd255);
        make_long_name(255, 63);
        make_long_name(258, 63);
        make_long_name(64, 64);
        fill_names(40);
        wait_idle();

        write_max_length(8'd1);
        fill_names(30);
        wait_idle();

        // zero limit rejects anything non-empty
        write_max_length(8'd0);
        fill_names(25);
        wait_idle();

        // receiver backs off long enough for the input to stall
        write_max_length(8'd20);
        @(posedge clk);
        long_holds_wanted <= long_holds_wanted + 1;
        fill_names(90);
        wait_idle();

        repeat (3)
        begin
            write_max_length(8'($urandom_range(2, 254)));
            fill_names(20);
            wait_idle();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/hsc_pkg.sv
src/hsc_front.sv
src/hsc_fifo.sv
src/hsc_back.sv
src/hostname_syntax_checker.sv
sim/testbench.sv
